// ----- src/aes256d_pkg.sv -----
// ----------------------------------------------------------------------------
// aes256d_pkg
// Shared constants, types and GF(2^8) helpers for the AES-256 block decrypter.
// ----------------------------------------------------------------------------
package aes256d_pkg;

	localparam int ROUND_COUNT_DEF = 14;
	localparam int SLOT_W = 5;
	localparam int HALF_W = 64;
	localparam int BLOCK_W = 128;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	typedef logic [7:0] sbox_t [256];

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ x;
			end
			x = xtime(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	// inverse affine map, then multiplicative inverse as x^254
	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		logic [7:0] r;
		logic [7:0] base;
		logic [7:0] e;
		b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
		r = 8'h01;
		base = b;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) begin
				r = gf_mul(r, base);
			end
			base = gf_mul(base, base);
		end
		return r;
	endfunction

	function automatic sbox_t build_inv_sbox();
		sbox_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv_sbox_calc(8'(i));
		end
		return t;
	endfunction

	localparam sbox_t INV_SBOX = build_inv_sbox();

endpackage

// ----- src/aes256d_key_store.sv -----
// ----------------------------------------------------------------------------
// aes256d_key_store
// Round key memory: one high and one low half per round, registered read.
// ----------------------------------------------------------------------------
module aes256d_key_store #(
	parameter int ROUND_COUNT = aes256d_pkg::ROUND_COUNT_DEF,
	parameter int RW = $clog2(ROUND_COUNT + 1)
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic                               wr_low,
	input  logic [RW-1:0]                      wr_round,
	input  logic [aes256d_pkg::HALF_W-1:0]     wr_data,
	input  logic [RW-1:0]                      rd_round,
	output logic [aes256d_pkg::BLOCK_W-1:0]    rd_key
);

	logic [aes256d_pkg::HALF_W-1:0] hi_mem [ROUND_COUNT+1];
	logic [aes256d_pkg::HALF_W-1:0] lo_mem [ROUND_COUNT+1];
	logic [aes256d_pkg::BLOCK_W-1:0] key_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_low) begin
			hi_mem[wr_round] <= wr_data;
		end
		if (wr_en && wr_low) begin
			lo_mem[wr_round] <= wr_data;
		end
		key_q <= {hi_mem[rd_round], lo_mem[rd_round]};
	end

	assign rd_key = key_q;

endmodule

// ----- src/aes256d_round.sv -----
// ----------------------------------------------------------------------------
// aes256d_round
// Inverse round: InvShiftRows, InvSubBytes, AddRoundKey; mix_en: InvMixColumns
// ----------------------------------------------------------------------------
module aes256d_round (
	input  logic [aes256d_pkg::BLOCK_W-1:0] state_in,
	input  logic [aes256d_pkg::BLOCK_W-1:0] round_key,
	input  logic                            mix_en,
	output logic [aes256d_pkg::BLOCK_W-1:0] state_out
);

	logic [7:0] sb [16];
	logic [7:0] ak [16];
	logic [7:0] mx [16];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[4*c+r] = aes256d_pkg::INV_SBOX[
					state_in[127 - 8*(4*((c - r + 4) & 3) + r) -: 8]];
			end
		end
		for (int i = 0; i < 16; i++) begin
			ak[i] = sb[i] ^ round_key[127 - 8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			mx[4*c]   = aes256d_pkg::gf_mul(ak[4*c], 8'd14) ^
				aes256d_pkg::gf_mul(ak[4*c+1], 8'd11) ^
				aes256d_pkg::gf_mul(ak[4*c+2], 8'd13) ^
				aes256d_pkg::gf_mul(ak[4*c+3], 8'd9);
			mx[4*c+1] = aes256d_pkg::gf_mul(ak[4*c], 8'd9) ^
				aes256d_pkg::gf_mul(ak[4*c+1], 8'd14) ^
				aes256d_pkg::gf_mul(ak[4*c+2], 8'd11) ^
				aes256d_pkg::gf_mul(ak[4*c+3], 8'd13);
			mx[4*c+2] = aes256d_pkg::gf_mul(ak[4*c], 8'd13) ^
				aes256d_pkg::gf_mul(ak[4*c+1], 8'd9) ^
				aes256d_pkg::gf_mul(ak[4*c+2], 8'd14) ^
				aes256d_pkg::gf_mul(ak[4*c+3], 8'd11);
			mx[4*c+3] = aes256d_pkg::gf_mul(ak[4*c], 8'd11) ^
				aes256d_pkg::gf_mul(ak[4*c+1], 8'd13) ^
				aes256d_pkg::gf_mul(ak[4*c+2], 8'd9) ^
				aes256d_pkg::gf_mul(ak[4*c+3], 8'd14);
		end
		for (int i = 0; i < 16; i++) begin
			state_out[127 - 8*i -: 8] = mix_en ? mx[i] : ak[i];
		end
	end

endmodule

// ----- src/aes256_block_decrypt.sv -----
// ----------------------------------------------------------------------------
// aes256_block_decrypt
// AES-256 inverse cipher on one block per transfer, round keys loaded from
// outside into an internal key memory.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | req_type, key_slot, data_hi, data_lo
//   out     | output    | out_valid / out_ready| plain_hi, plain_lo
//
// a load transfer gives no result
// a decrypt goes through the key memory read register, the first key
// addition (ST_FIRST), then ST_ROUND once per round on the shared round
// unit
// in_ready is low while a block is in flight; the last round waits while an
// earlier result is still held on the out channel
// reset clears the sequencer and out_valid; the key memory is not cleared
// ----------------------------------------------------------------------------
module aes256_block_decrypt #(
	parameter int ROUND_COUNT = aes256d_pkg::ROUND_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [aes256d_pkg::SLOT_W-1:0]      key_slot,
	input  logic [aes256d_pkg::HALF_W-1:0]      data_hi,
	input  logic [aes256d_pkg::HALF_W-1:0]      data_lo,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [aes256d_pkg::HALF_W-1:0]      plain_hi,
	output logic [aes256d_pkg::HALF_W-1:0]      plain_lo
);

	localparam int RW = $clog2(ROUND_COUNT + 1);
	localparam int KEY_SLOTS = 2 * (ROUND_COUNT + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_ROUND
	} seq_state_t;

	typedef struct packed {
		logic          wr_en;
		logic          wr_low;
		logic [RW-1:0] wr_round;
		logic [RW-1:0] rd_round;
	} key_ctl_t;

	seq_state_t                     seq_q;
	logic [RW-1:0]                  rnd_q;
	logic [aes256d_pkg::BLOCK_W-1:0] state_q;
	logic [aes256d_pkg::BLOCK_W-1:0] res_q;
	logic                           out_valid_q;
	logic [aes256d_pkg::BLOCK_W-1:0] round_key;
	logic [aes256d_pkg::BLOCK_W-1:0] round_out;
	key_ctl_t                       key_ctl;
	logic                           in_xfer;
	logic                           res_free;

	assign in_ready = (seq_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign res_free = !out_valid_q || out_ready;

	always_comb begin
		key_ctl.wr_en = in_xfer && (req_type == aes256d_pkg::REQ_LOAD) &&
			({1'b0, key_slot} < (aes256d_pkg::SLOT_W + 1)'(KEY_SLOTS));
		key_ctl.wr_low = key_slot[0];
		key_ctl.wr_round = RW'(key_slot[aes256d_pkg::SLOT_W-1:1]);
		case (seq_q)
			ST_IDLE:  key_ctl.rd_round = RW'(ROUND_COUNT);
			ST_FIRST: key_ctl.rd_round = RW'(ROUND_COUNT - 1);
			ST_ROUND: key_ctl.rd_round = (rnd_q == '0) ? '0 : rnd_q - RW'(1);
			default:  key_ctl.rd_round = RW'(ROUND_COUNT);
		endcase
	end

	aes256d_key_store #(
		.ROUND_COUNT(ROUND_COUNT),
		.RW(RW)
	) u_key_store (
		.clk(clk),
		.wr_en(key_ctl.wr_en),
		.wr_low(key_ctl.wr_low),
		.wr_round(key_ctl.wr_round),
		.wr_data(data_hi),
		.rd_round(key_ctl.rd_round),
		.rd_key(round_key)
	);

	aes256d_round u_round (
		.state_in(state_q),
		.round_key(round_key),
		.mix_en(rnd_q != '0),
		.state_out(round_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ST_IDLE;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a finishing block refills the result register in the same cycle
			if (out_valid_q && out_ready && !(seq_q == ST_ROUND && rnd_q == '0)) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				ST_IDLE: begin
					if (in_xfer && (req_type == aes256d_pkg::REQ_DECRYPT)) begin
						state_q <= {data_hi, data_lo};
						seq_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= state_q ^ round_key;
					rnd_q <= RW'(ROUND_COUNT - 1);
					seq_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (rnd_q != '0) begin
						state_q <= round_out;
						rnd_q <= rnd_q - RW'(1);
					end else if (res_free) begin
						// final round goes straight to the result register
						res_q <= round_out;
						out_valid_q <= 1'b1;
						seq_q <= ST_IDLE;
					end
				end
				default: begin
					seq_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign plain_hi = res_q[aes256d_pkg::BLOCK_W-1:aes256d_pkg::HALF_W];
	assign plain_lo = res_q[aes256d_pkg::HALF_W-1:0];

endmodule

// ----- sim/aes256_block_decrypt_tb.sv -----
// ----------------------------------------------------------------------------
// aes256_block_decrypt_tb
// Self-checking bench for the AES-256 block decrypter. Round key halves are
// loaded into the key memory, blocks are decrypted, and every plaintext
// transfer is compared with a local inverse cipher that keeps its own copy
// of the key memory. The in side idles and the out side stalls at random.
// ----------------------------------------------------------------------------
module aes256_block_decrypt_tb;

	localparam int ROUNDS = aes256d_pkg::ROUND_COUNT_DEF;
	localparam int KEY_SLOTS = 2 * (ROUNDS + 1);
	localparam int QUIET_LIMIT = 400;
	localparam int DRAIN_CYCLES = 2 * (ROUNDS + 2) + 8;
	localparam int RANDOM_ITEMS = 1800;
	localparam int TAIL_ITEMS = 200;

	typedef struct packed {
		logic [aes256d_pkg::HALF_W-1:0] hi;
		logic [aes256d_pkg::HALF_W-1:0] lo;
	} plain_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           req_type;
	logic [aes256d_pkg::SLOT_W-1:0] key_slot;
	logic [aes256d_pkg::HALF_W-1:0] data_hi;
	logic [aes256d_pkg::HALF_W-1:0] data_lo;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [aes256d_pkg::HALF_W-1:0] plain_hi;
	logic [aes256d_pkg::HALF_W-1:0] plain_lo;

	logic [7:0]                     unsub_table [256];
	logic [aes256d_pkg::HALF_W-1:0] key_half [KEY_SLOTS];
	plain_t                         plain_q [$];
	plain_t                         want_plain;
	int                             fail_count = 0;
	int                             quiet_cycles = 0;
	int                             stall_left = 0;
	bit                             allow_idle = 1'b1;

	aes256_block_decrypt #(.ROUND_COUNT(ROUNDS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.key_slot  (key_slot),
		.data_hi   (data_hi),
		.data_lo   (data_lo),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.plain_hi  (plain_hi),
		.plain_lo  (plain_lo)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// inverse cipher
	// ------------------------------------------------------------------------
	function automatic logic [7:0] ff_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] aa;
		acc = 8'h00;
		aa = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ aa;
			end
			aa = {aa[6:0], 1'b0} ^ (aa[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	// forward s-box from reciprocal plus affine map, then stored inverted
	task automatic build_unsub_table();
		logic [7:0] recip;
		logic [7:0] fwd;
		for (int x = 0; x < 256; x++) begin
			recip = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (ff_mult(8'(x), 8'(y)) == 8'h01) begin
					recip = 8'(y);
				end
			end
			fwd = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]}
				^ {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
			unsub_table[fwd] = 8'(x);
		end
	endtask

	function automatic logic [127:0] round_key(input int rnd);
		return {key_half[2 * rnd], key_half[2 * rnd + 1]};
	endfunction

	// byte i sits at bits 127-8i; byte i is row i%4, column i/4
	function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (4 * c + r) -: 8] =
					unsub_table[s[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] unmix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = ff_mult(a0, 8'd14) ^ ff_mult(a1, 8'd11)
				^ ff_mult(a2, 8'd13) ^ ff_mult(a3, 8'd9);
			t[119 - 32 * c -: 8] = ff_mult(a0, 8'd9) ^ ff_mult(a1, 8'd14)
				^ ff_mult(a2, 8'd11) ^ ff_mult(a3, 8'd13);
			t[111 - 32 * c -: 8] = ff_mult(a0, 8'd13) ^ ff_mult(a1, 8'd9)
				^ ff_mult(a2, 8'd14) ^ ff_mult(a3, 8'd11);
			t[103 - 32 * c -: 8] = ff_mult(a0, 8'd11) ^ ff_mult(a1, 8'd13)
				^ ff_mult(a2, 8'd9) ^ ff_mult(a3, 8'd14);
		end
		return t;
	endfunction

	function automatic plain_t decipher_block(input logic [aes256d_pkg::HALF_W-1:0] c_hi,
			input logic [aes256d_pkg::HALF_W-1:0] c_lo);
		logic [127:0] s;
		s = {c_hi, c_lo} ^ round_key(ROUNDS);
		for (int rnd = ROUNDS - 1; rnd >= 1; rnd--) begin
			s = unmix(unshift_unsub(s) ^ round_key(rnd));
		end
		s = unshift_unsub(s) ^ round_key(0);
		return '{hi: s[127:64], lo: s[63:0]};
	endfunction

	// ------------------------------------------------------------------------
	// in channel
	// ------------------------------------------------------------------------
	// called and returns at a falling edge; valid stays high after return
	task automatic send_item(input logic req, input logic [aes256d_pkg::SLOT_W-1:0] slot,
			input logic [aes256d_pkg::HALF_W-1:0] hi,
			input logic [aes256d_pkg::HALF_W-1:0] lo);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		key_slot <= slot;
		data_hi <= hi;
		data_lo <= lo;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (req == aes256d_pkg::REQ_DECRYPT) begin
			plain_q.push_back(decipher_block(hi, lo));
		end else if (slot < KEY_SLOTS) begin
			key_half[slot] = hi;
		end
		@(negedge clk);
	endtask

	task automatic wait_plain_drained();
		in_valid <= 1'b0;
		while (plain_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic logic [aes256d_pkg::HALF_W-1:0] pick_half();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// out channel: ready with random stall bursts
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (allow_idle && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (plain_q.size() == 0) begin
				$error("plaintext transfer with no block outstanding: %h %h",
					plain_hi, plain_lo);
				fail_count++;
			end else begin
				want_plain = plain_q.pop_front();
				if (plain_hi !== want_plain.hi) begin
					$error("plain_hi mismatch: expected %h, actual %h", want_plain.hi,
						plain_hi);
					fail_count++;
				end
				if (plain_lo !== want_plain.lo) begin
					$error("plain_lo mismatch: expected %h, actual %h", want_plain.lo,
						plain_lo);
					fail_count++;
				end
			end
		end
	end

	// quiet-cycle watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_extreme_blocks();
		// every slot written before the first decrypt
		for (int s = 0; s < KEY_SLOTS; s++) begin
			send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(s), '0, '1);
		end
		send_item(aes256d_pkg::REQ_DECRYPT, '0, '0, '0);
		send_item(aes256d_pkg::REQ_DECRYPT, '0, '1, '1);
		send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(2 * ROUNDS), '1, '0);
		send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(2 * ROUNDS + 1), '1, '1);
		send_item(aes256d_pkg::REQ_DECRYPT, '0, '0, '0);
		send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(0), '1, '0);
		send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(1), '1, '0);
		send_item(aes256d_pkg::REQ_DECRYPT, '1, '1, '0);
		send_item(aes256d_pkg::REQ_DECRYPT, '1, 64'h8000_0000_0000_0000,
			64'h0000_0000_0000_0001);
		send_item(aes256d_pkg::REQ_DECRYPT, '0, 64'h0123_4567_89ab_cdef,
			64'hfedc_ba98_7654_3210);
	endtask

	// loads beyond the key memory change nothing
	task automatic test_slots_out_of_range();
		send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(KEY_SLOTS),
			{$urandom, $urandom}, '1);
		send_item(aes256d_pkg::REQ_LOAD, '1, '1, '0);
		send_item(aes256d_pkg::REQ_DECRYPT, '0, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(aes256d_pkg::REQ_DECRYPT, '1, '0, '1);
	endtask

	task automatic test_fresh_keys_after_drain();
		wait_plain_drained();
		for (int s = 0; s < KEY_SLOTS; s++) begin
			send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'(s), {$urandom, $urandom},
				{$urandom, $urandom});
		end
		repeat (4) begin
			send_item(aes256d_pkg::REQ_DECRYPT, aes256d_pkg::SLOT_W'($urandom), pick_half(),
				pick_half());
		end
	endtask

	task automatic send_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_item(aes256d_pkg::REQ_LOAD, aes256d_pkg::SLOT_W'($urandom_range(0, 31)),
					pick_half(), pick_half());
			end else begin
				send_item(aes256d_pkg::REQ_DECRYPT, aes256d_pkg::SLOT_W'($urandom),
					pick_half(), pick_half());
			end
			if (i % 600 == 599) begin
				wait_plain_drained();
			end
		end
	endtask

	task automatic test_random_traffic();
		send_random_mix(RANDOM_ITEMS);
	endtask

	task automatic test_back_to_back_tail();
		allow_idle = 1'b0;
		send_random_mix(TAIL_ITEMS);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = aes256d_pkg::REQ_LOAD;
		key_slot = '0;
		data_hi = '0;
		data_lo = '0;
		build_unsub_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extreme_blocks();
		test_slots_out_of_range();
		test_fresh_keys_after_drain();
		test_random_traffic();
		test_back_to_back_tail();

		in_valid <= 1'b0;
		while (plain_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
